[hw/rtl/dopq_pkg.sv]
package dopq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;
   localparam int unsigned PRIO_W = 64;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned OCC_W = 5;

   // operation codes
   typedef enum logic [1:0] {
      FUNC_ENQUEUE = 2'd0,
      FUNC_PEEK    = 2'd1,
      FUNC_REMOVE  = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   // item handed from front to back
   typedef struct packed {
      func_type           func;
      logic [PRIO_W-1:0]  prio_value;
      logic               by_priority;
      logic [SLOT_W-1:0]  slot_in;
   } cmd_type;

   // signed less-than on raw patterns
   function automatic logic prio_less(input logic [PRIO_W-1:0] a,
                                      input logic [PRIO_W-1:0] b);
      prio_less = $signed(a) < $signed(b);
   endfunction

endpackage

[hw/rtl/dopq_if.sv]
interface dopq_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   func;
   logic [dopq_pkg::PRIO_W-1:0]  prio_value;
   logic                         by_priority;
   logic [dopq_pkg::SLOT_W-1:0]  slot_in;
   modport source (output valid, func, prio_value, by_priority, slot_in, input ready);
   modport sink (input valid, func, prio_value, by_priority, slot_in, output ready);
endinterface

interface dopq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [dopq_pkg::SLOT_W-1:0]  slot_out;
   logic [dopq_pkg::PRIO_W-1:0]  prio_out;
   logic [dopq_pkg::OCC_W-1:0]   occupancy;
   modport source (output valid, status, slot_out, prio_out, occupancy, input ready);
   modport sink (input valid, status, slot_out, prio_out, occupancy, output ready);
endinterface

[hw/rtl/dopq_front.sv]
module dopq_front (
   input  logic                clock,
   input  logic                reset,
   dopq_req_if.sink            req,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output dopq_pkg::cmd_type   cmd
);

   // two-entry command queue
   dopq_pkg::cmd_type  buf_ff [2];
   dopq_pkg::cmd_type  buf_in [2];
   logic [1:0]         cnt_ff, cnt_in;
   logic               push, pop;
   dopq_pkg::cmd_type  in_cmd;

   // classify: raw code onto the operation type
   always_comb begin
      in_cmd.func        = dopq_pkg::func_type'(req.func);
      in_cmd.prio_value  = req.prio_value;
      in_cmd.by_priority = req.by_priority;
      in_cmd.slot_in     = req.slot_in;
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = buf_ff[0];

   // queue update
   always_comb begin
      buf_in[0] = buf_ff[0];
      buf_in[1] = buf_ff[1];
      cnt_in    = cnt_ff;
      if (pop) begin
         buf_in[0] = buf_ff[1];
         cnt_in    = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) buf_in[0] = in_cmd;
         else                buf_in[1] = in_cmd;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff[0] <= buf_in[0];
      buf_ff[1] <= buf_in[1];
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end

`ifndef ASSERT_OFF
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("command queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("command queue lost entries while full");
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("command queue count wrong on pop");
`endif

endmodule

[hw/rtl/dopq_back.sv]
module dopq_back #(
   parameter int unsigned QUEUE_DEPTH = dopq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  dopq_pkg::cmd_type   cmd,
   dopq_rsp_if.source          rsp
);

   localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PW = dopq_pkg::PRIO_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DONE = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   dopq_pkg::cmd_type  cur_ff, cur_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [PW-1:0]      prio_mem [QUEUE_DEPTH];
   logic [IDX_W-1:0]   rank_mem [QUEUE_DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W:0]     idx_ff, idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [PW-1:0]      pprio_ff, pprio_in;
   logic [IDX_W-1:0]   prank_ff, prank_in;
   logic [IDX_W-1:0]   del_rank_ff, del_rank_in;
   logic [1:0]         st_out_ff, st_out_in;
   logic [dopq_pkg::SLOT_W-1:0] slot_out_ff, slot_out_in;
   logic [PW-1:0]      prio_out_ff, prio_out_in;
   logic [IDX_W-1:0]   ia;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [PW-1:0]      wr_prio;
   logic [IDX_W-1:0]   wr_rank;
   logic               dec_en;
   logic               better;
   logic               slot_ok;
   logic [IDX_W-1:0]   slot_idx;

   assign ia        = idx_ff[IDX_W-1:0];
   assign cmd_ready = (state_ff == ST_IDLE);
   assign slot_ok   = ({{(32-dopq_pkg::SLOT_W){1'b0}}, cmd.slot_in} < QUEUE_DEPTH);
   assign slot_idx  = IDX_W'(cmd.slot_in);

   // candidate comparison for the peek scan
   always_comb begin
      if (cur_ff.by_priority)
         better = dopq_pkg::prio_less(prio_mem[ia], pprio_ff) ||
                  (prio_mem[ia] == pprio_ff && rank_mem[ia] < prank_ff);
      else
         better = rank_mem[ia] < prank_ff;
   end

   // sequencer: one slot per scan cycle
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      pprio_in    = pprio_ff;
      prank_in    = prank_ff;
      del_rank_in = del_rank_ff;
      st_out_in   = st_out_ff;
      slot_out_in = slot_out_ff;
      prio_out_in = prio_out_ff;
      wr_en       = 1'b0;
      wr_idx      = ia;
      wr_prio     = cur_ff.prio_value;
      wr_rank     = count_ff[IDX_W-1:0];
      dec_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cur_in   = cmd;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
               if (cmd.func == dopq_pkg::FUNC_REMOVE) begin
                  slot_out_in = cmd.slot_in;
                  if (slot_ok && valid_ff[slot_idx]) begin
                     prio_out_in  = prio_mem[slot_idx];
                     del_rank_in  = rank_mem[slot_idx];
                     valid_in[slot_idx] = 1'b0;
                     count_in     = count_ff - CNT_W'(1);
                     st_out_in    = dopq_pkg::STATUS_OK;
                  end else begin
                     prio_out_in = '0;
                     st_out_in   = dopq_pkg::STATUS_NONE;
                     state_in    = ST_OUT;
                  end
               end else if (cmd.func == dopq_pkg::FUNC_UNUSED) begin
                  st_out_in   = dopq_pkg::STATUS_NONE;
                  slot_out_in = '0;
                  prio_out_in = '0;
                  state_in    = ST_OUT;
               end
            end
         end
         ST_SCAN: begin
            unique case (cur_ff.func)
               dopq_pkg::FUNC_ENQUEUE: begin
                  if (!valid_ff[ia]) begin
                     wr_en         = 1'b1;
                     valid_in[ia]  = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     found_in      = 1'b1;
                     pick_in       = ia;
                     state_in      = ST_DONE;
                  end
               end
               dopq_pkg::FUNC_PEEK: begin
                  if (valid_ff[ia] && (!found_ff || better)) begin
                     found_in = 1'b1;
                     pick_in  = ia;
                     pprio_in = prio_mem[ia];
                     prank_in = rank_mem[ia];
                  end
               end
               default: begin
                  if (valid_ff[ia] && rank_mem[ia] > del_rank_ff) dec_en = 1'b1;
               end
            endcase
            if (state_in == ST_SCAN) begin
               if (idx_ff == (IDX_W+1)'(QUEUE_DEPTH - 1)) state_in = ST_DONE;
               else idx_in = idx_ff + (IDX_W+1)'(1);
            end
         end
         ST_DONE: begin
            state_in = ST_OUT;
            if (cur_ff.func == dopq_pkg::FUNC_ENQUEUE) begin
               st_out_in   = found_ff ? dopq_pkg::STATUS_OK : dopq_pkg::STATUS_FULL;
               slot_out_in = found_ff ? dopq_pkg::SLOT_W'(pick_ff) : '0;
               prio_out_in = found_ff ? cur_ff.prio_value : '0;
            end else if (cur_ff.func == dopq_pkg::FUNC_PEEK) begin
               if (!found_ff || (cur_ff.by_priority &&
                   dopq_pkg::prio_less(cur_ff.prio_value, pprio_ff))) begin
                  st_out_in   = dopq_pkg::STATUS_NONE;
                  slot_out_in = '0;
                  prio_out_in = '0;
               end else begin
                  st_out_in   = dopq_pkg::STATUS_OK;
                  slot_out_in = dopq_pkg::SLOT_W'(pick_ff);
                  prio_out_in = pprio_ff;
               end
            end
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // slot store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prio_mem[wr_idx] <= wr_prio;
         rank_mem[wr_idx] <= wr_rank;
      end else if (dec_en) begin
         rank_mem[ia] <= rank_mem[ia] - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      pprio_ff    <= pprio_in;
      prank_ff    <= prank_in;
      del_rank_ff <= del_rank_in;
      st_out_ff   <= st_out_in;
      slot_out_ff <= slot_out_in;
      prio_out_ff <= prio_out_in;
   end

   assign rsp.valid     = (state_ff == ST_OUT);
   assign rsp.status    = st_out_ff;
   assign rsp.slot_out  = slot_out_ff;
   assign rsp.prio_out  = prio_out_ff;
   assign rsp.occupancy = dopq_pkg::OCC_W'(count_ff);

`ifndef ASSERT_OFF
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> count_ff == CNT_W'($countones(valid_ff)))
      else $error("entry count differs from valid slots");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(st_out_ff))
      else $error("result changed while stalled");
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
`endif

endmodule

[hw/rtl/dual_order_priority_queue_unit.sv]
// dual_order_priority_queue_unit: slot pool kept in arrival and priority order.
// req channel carries one item per operation: func (enqueue, peek, remove),
// prio_value (new priority or peek limit), by_priority and slot_in.
// rsp channel returns exactly one item per request: status, slot_out,
// prio_out and occupancy after the operation.
// a two-entry command queue in front takes items while the back end works.
// the back end scans the slot store one slot per cycle:
//   enqueue: stops at the first free slot, or scans every slot when full
//   peek and successful remove: scan every slot
//   failed remove and unused codes: no scan, straight to the result
// each item first passes the command queue register; the scan loop sets the rate.
// the result sits in an output register until rsp.ready; while the receiver
// stalls, the back end holds and the front queue fills, then req.ready drops.
// reset (synchronous, active high) empties the queue at once: all slots free,
// occupancy zero, no clearing pass.
module dual_order_priority_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = dopq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dopq_req_if.sink   req,
   dopq_rsp_if.source rsp
);

   logic               cmd_valid;
   logic               cmd_ready;
   dopq_pkg::cmd_type  cmd;

   // front: accept and queue items
   dopq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // back: execute on the slot store
   dopq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp       (rsp)
   );

endmodule

[dv/tb_dual_order_priority_queue_unit.sv]
module tb_dual_order_priority_queue_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH = dopq_pkg::QUEUE_DEPTH_DEFAULT;

   typedef struct {
      dopq_pkg::status_type status;
      logic [3:0]       slot_out;
      logic [63:0]      prio_out;
      logic [4:0]       occupancy;
   } queue_reply_t;

   // queue mirror and expected replies
   class queue_scoreboard;
      bit               busy[DEPTH];
      logic [63:0]      prio_of[DEPTH];
      int unsigned      rank_of[DEPTH];
      int unsigned      count;
      queue_reply_t     pending[$];
      int unsigned      errors;

      function void clear();
         foreach (busy[i]) begin
            busy[i] = 0;
            prio_of[i] = '0;
            rank_of[i] = 0;
         end
         count = 0;
      endfunction

      function void note_request(dopq_pkg::func_type f, logic [63:0] pv, logic bp,
                                 logic [3:0] si);
         queue_reply_t r;
         bit           found;
         int unsigned  pick;
         int unsigned  held_rank;
         found = 0;
         pick = 0;
         r.status = dopq_pkg::STATUS_NONE;
         r.slot_out = '0;
         r.prio_out = '0;
         case (f)
            dopq_pkg::FUNC_ENQUEUE: begin
               r.status = dopq_pkg::STATUS_FULL;
               for (int i = 0; i < DEPTH; i++) begin
                  if (!found && !busy[i]) begin
                     found = 1;
                     busy[i] = 1;
                     prio_of[i] = pv;
                     rank_of[i] = count;
                     count++;
                     r.status = dopq_pkg::STATUS_OK;
                     r.slot_out = 4'(i);
                     r.prio_out = pv;
                  end
               end
            end
            dopq_pkg::FUNC_PEEK: begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (busy[i]) begin
                     if (!found) begin
                        pick = i;
                        found = 1;
                     end else if (bp) begin
                        if ($signed(prio_of[i]) < $signed(prio_of[pick]) ||
                            (prio_of[i] == prio_of[pick] && rank_of[i] < rank_of[pick]))
                           pick = i;
                     end else if (rank_of[i] < rank_of[pick]) begin
                        pick = i;
                     end
                  end
               end
               if (found && !(bp && $signed(pv) < $signed(prio_of[pick]))) begin
                  r.status = dopq_pkg::STATUS_OK;
                  r.slot_out = 4'(pick);
                  r.prio_out = prio_of[pick];
               end
            end
            dopq_pkg::FUNC_REMOVE: begin
               r.slot_out = si;
               if (busy[si]) begin
                  held_rank = rank_of[si];
                  busy[si] = 0;
                  for (int i = 0; i < DEPTH; i++)
                     if (busy[i] && rank_of[i] > held_rank) rank_of[i]--;
                  if (count > 0) count--;
                  r.status = dopq_pkg::STATUS_OK;
                  r.prio_out = prio_of[si];
               end
            end
            default: ;
         endcase
         r.occupancy = 5'(count);
         pending.push_back(r);
      endfunction

      function void check_reply(logic [1:0] st, logic [3:0] so, logic [63:0] po,
                                logic [4:0] oc);
         queue_reply_t e;
         if (pending.size() == 0) begin
            $error("reply with nothing pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) begin
            $error("status expected %0d got %0d", e.status, st);
            errors++;
         end
         if (so !== e.slot_out) begin
            $error("slot_out expected %0d got %0d", e.slot_out, so);
            errors++;
         end
         if (po !== e.prio_out) begin
            $error("prio_out expected %h got %h", e.prio_out, po);
            errors++;
         end
         if (oc !== e.occupancy) begin
            $error("occupancy expected %0d got %0d", e.occupancy, oc);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   dopq_req_if req_if ();
   dopq_rsp_if rsp_if ();
   queue_scoreboard board;
   int unsigned burst_left;

   dual_order_priority_queue_unit dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // reply checking and receiver stalls
   initial begin
      rsp_if.ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            board.check_reply(rsp_if.status, rsp_if.slot_out, rsp_if.prio_out,
                              rsp_if.occupancy);
         if ($urandom_range(0, 3) == 0 && ($time / 4000) % 3 != 0)
            rsp_if.ready <= ($urandom_range(0, 1) == 0);
         else
            rsp_if.ready <= 1;
      end
   end

   // send one item, idling between bursts
   task automatic send_item(dopq_pkg::func_type f, logic [63:0] pv, logic bp,
                            logic [3:0] si);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_if.valid <= 1;
      req_if.func <= f;
      req_if.prio_value <= pv;
      req_if.by_priority <= bp;
      req_if.slot_in <= si;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_request(f, pv, bp, si);
   endtask

   function automatic logic [63:0] pick_prio();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7FFF_FFFF_FFFF_FFFF;
         2: return {$urandom, $urandom};
         default: return 64'($signed($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   function automatic logic [3:0] pick_slot();
      int unsigned tries;
      logic [3:0]  s;
      for (tries = 0; tries < 8; tries++) begin
         s = 4'($urandom_range(0, DEPTH - 1));
         if (board.busy[s]) return s;
      end
      return 4'($urandom_range(0, DEPTH - 1));
   endfunction

   // stimulus
   initial begin
      int unsigned target;
      int unsigned wait_cycles;
      board = new();
      board.clear();
      burst_left = 0;
      reset = 1;
      req_if.valid = 0;
      req_if.func = dopq_pkg::FUNC_ENQUEUE;
      req_if.prio_value = '0;
      req_if.by_priority = 0;
      req_if.slot_in = '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty peeks, fill past full, limits, removes, unused code
      send_item(dopq_pkg::FUNC_PEEK, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 4'd0);
      send_item(dopq_pkg::FUNC_PEEK, '0, 1'b0, 4'd0);
      send_item(dopq_pkg::FUNC_REMOVE, '0, 1'b0, 4'd15);
      for (int i = 0; i < DEPTH; i++)
         send_item(dopq_pkg::FUNC_ENQUEUE, (i % 3 == 0) ? 64'h8000_0000_0000_0000 :
                   (i % 3 == 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'd5, 1'b0, 4'd0);
      send_item(dopq_pkg::FUNC_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 4'd0);
      send_item(dopq_pkg::FUNC_PEEK, 64'h8000_0000_0000_0000, 1'b1, 4'd0);
      send_item(dopq_pkg::FUNC_REMOVE, '0, 1'b0, 4'd0);
      send_item(dopq_pkg::FUNC_PEEK, 64'h8000_0000_0000_0000, 1'b1, 4'd0);
      send_item(dopq_pkg::FUNC_PEEK, '0, 1'b0, 4'd0);
      send_item(dopq_pkg::FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'hF);

      // random mix, drifting between nearly empty and nearly full
      for (int n = 0; n < 1200; n++) begin
         int unsigned bias;
         bias = ((n / 150) % 2 == 0) ? 60 : 30;
         target = $urandom_range(0, 99);
         if (target < bias)
            send_item(dopq_pkg::FUNC_ENQUEUE, pick_prio(), 1'($urandom_range(0, 1)),
                      4'($urandom));
         else if (target < bias + 20)
            send_item(dopq_pkg::FUNC_PEEK, pick_prio(), 1'($urandom_range(0, 1)),
                      4'($urandom));
         else if (target < 98)
            send_item(dopq_pkg::FUNC_REMOVE, {$urandom, $urandom},
                      1'($urandom_range(0, 1)), pick_slot());
         else
            send_item(dopq_pkg::FUNC_UNUSED, pick_prio(), 1'($urandom_range(0, 1)),
                      4'($urandom));
      end
      req_if.valid <= 0;

      // drain
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[dual_order_priority_queue_unit] OK");
      else
         $display("[dual_order_priority_queue_unit] ERROR");
      $finish;
   end

   // run limit
   initial begin
      #3ms;
      $display("[dual_order_priority_queue_unit] ERROR");
      $finish;
   end

endmodule

[files.f]
hw/rtl/dopq_pkg.sv
hw/rtl/dopq_if.sv
hw/rtl/dopq_front.sv
hw/rtl/dopq_back.sv
hw/rtl/dual_order_priority_queue_unit.sv
dv/tb_dual_order_priority_queue_unit.sv
